@@ rtl/haversine_distance_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the haversine distance core
// Concurrent checks on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HAVERSINE_DISTANCE_CORE_ASSERT_SVH
`define HAVERSINE_DISTANCE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define HVD_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hvd assertion failed");
`define HVD_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("hvd assertion failed");
`else
`define HVD_ASSERT_IMPLIES(lbl, ante, cons)
`define HVD_ASSERT_ALWAYS(lbl, cond)
`endif

`endif

@@ rtl/hvd_pkg.sv @@
// ----------------------------------------------------------------------------
// hvd_pkg
// Shared types, fixed-point constants and tables of the haversine core.
// ----------------------------------------------------------------------------
package hvd_pkg;

    typedef logic signed [32:0] t_cw;   // CORDIC working word
    typedef logic signed [31:0] t_q30;  // signed Q30 value

    localparam logic signed [26:0] TURN_Q17 = 27'sd47185920;
    localparam logic [26:0]        RECIP45  = 27'd95443718;   // ceil(2^32 / 45)
    localparam logic signed [32:0] GAIN_Q30 = 33'sd652032874;
    localparam logic [30:0]        ONE_Q30  = 31'd1073741824;
    localparam logic [30:0]        PI_Q29   = 31'd1686629713;

    localparam logic [29:0] ARC_TAB [32] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
        30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
    };

    // Low 12 bits of the binary angle for a remainder modulo 45.
    function automatic logic [11:0] frac45(input int unsigned rr);
        if (rr >= 45) begin
            return 12'd0;
        end
        return 12'((rr * 4096 + 22) / 45);
    endfunction

endpackage

@@ rtl/hvd_cordic_rot.sv @@
// ----------------------------------------------------------------------------
// hvd_cordic_rot
// Pipelined rotation-mode CORDIC: binary angle in, clamped Q30 cos/sin out.
// ----------------------------------------------------------------------------
module hvd_cordic_rot #(
    parameter int ITER = 24
) (
    input  logic               i_clk,
    input  logic [31:0]        i_ba,
    output hvd_pkg::t_q30      o_cos,
    output hvd_pkg::t_q30      o_sin
);

    logic [31:0]     w_sum;
    logic [31:0]     w_res;
    hvd_pkg::t_cw    r_x [ITER+1];
    hvd_pkg::t_cw    r_y [ITER+1];
    hvd_pkg::t_cw    r_z [ITER];
    logic [1:0]      r_quad [ITER+1];
    hvd_pkg::t_q30   r_cos;
    hvd_pkg::t_q30   r_sin;

    function automatic hvd_pkg::t_q30 clamp1(input logic signed [33:0] v);
        if (v > 34'sd1073741824) begin
            return 32'sd1073741824;
        end
        if (v < -34'sd1073741824) begin
            return -32'sd1073741824;
        end
        return 32'(v);
    endfunction

    // Fold the angle into the quadrant around zero.
    assign w_sum = i_ba + 32'h2000_0000;
    assign w_res = i_ba - {w_sum[31:30], 30'd0};

    always_ff @(posedge i_clk) begin
        r_x[0]    <= hvd_pkg::GAIN_Q30;
        r_y[0]    <= '0;
        r_z[0]    <= 33'($signed(w_res));
        r_quad[0] <= w_sum[31:30];
    end

    for (genvar g = 0; g < ITER; g++) begin : g_stage
        localparam logic signed [32:0] ARC = $signed({3'b000, hvd_pkg::ARC_TAB[g]});
        always_ff @(posedge i_clk) begin
            r_quad[g+1] <= r_quad[g];
            if (!r_z[g][32]) begin
                r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
            end else begin
                r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
            end
        end
        if (g < ITER - 1) begin : g_z
            always_ff @(posedge i_clk) begin
                r_z[g+1] <= r_z[g][32] ? r_z[g] + ARC : r_z[g] - ARC;
            end
        end
    end

    // Map back from the folded quadrant and clamp to +/-1.0.
    always_ff @(posedge i_clk) begin
        case (r_quad[ITER])
            2'd0: begin
                r_cos <= clamp1(34'(r_x[ITER]));
                r_sin <= clamp1(34'(r_y[ITER]));
            end
            2'd1: begin
                r_cos <= clamp1(-34'(r_y[ITER]));
                r_sin <= clamp1(34'(r_x[ITER]));
            end
            2'd2: begin
                r_cos <= clamp1(-34'(r_x[ITER]));
                r_sin <= clamp1(-34'(r_y[ITER]));
            end
            default: begin
                r_cos <= clamp1(34'(r_y[ITER]));
                r_sin <= clamp1(-34'(r_x[ITER]));
            end
        endcase
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

@@ rtl/hvd_isqrt.sv @@
// ----------------------------------------------------------------------------
// hvd_isqrt
// Pipelined digit-by-digit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module hvd_isqrt (
    input  logic        i_clk,
    input  logic [60:0] i_val,
    output logic [30:0] o_root
);

    localparam int STAGES = 31;

    logic [60:0] r_rem  [STAGES];
    logic [30:0] r_root [STAGES];

    for (genvar j = 0; j < STAGES; j++) begin : g_stage
        localparam int K = STAGES - 1 - j;
        logic [60:0] w_rem_in;
        logic [30:0] w_root_in;
        logic [62:0] w_trial;
        logic        w_take;

        if (j == 0) begin : g_first
            assign w_rem_in  = i_val;
            assign w_root_in = '0;
        end else begin : g_next
            assign w_rem_in  = r_rem[j-1];
            assign w_root_in = r_root[j-1];
        end

        assign w_trial = (63'(w_root_in) << (K + 1)) | (63'(1) << (2 * K));
        assign w_take  = 63'(w_rem_in) >= w_trial;

        always_ff @(posedge i_clk) begin
            r_root[j] <= w_take ? (w_root_in | (31'(1) << K)) : w_root_in;
            r_rem[j]  <= w_take ? 61'(63'(w_rem_in) - w_trial) : w_rem_in;
        end
    end

    assign o_root = r_root[STAGES-1];

endmodule

@@ rtl/hvd_cordic_vec.sv @@
// ----------------------------------------------------------------------------
// hvd_cordic_vec
// Pipelined vectoring-mode CORDIC: first-quadrant atan2 in binary angle units.
// ----------------------------------------------------------------------------
module hvd_cordic_vec #(
    parameter int ITER = 24
) (
    input  logic        i_clk,
    input  logic [30:0] i_x,
    input  logic [30:0] i_y,
    output logic [30:0] o_angle
);

    hvd_pkg::t_cw r_x [ITER];
    hvd_pkg::t_cw r_y [ITER];
    hvd_pkg::t_cw r_z [ITER];
    logic [30:0]  r_angle;

    for (genvar g = 0; g < ITER; g++) begin : g_stage
        localparam logic signed [32:0] ARC = $signed({3'b000, hvd_pkg::ARC_TAB[g]});
        hvd_pkg::t_cw w_x;
        hvd_pkg::t_cw w_y;
        hvd_pkg::t_cw w_z;

        if (g == 0) begin : g_first
            assign w_x = $signed({2'b00, i_x});
            assign w_y = $signed({2'b00, i_y});
            assign w_z = '0;
        end else begin : g_next
            assign w_x = r_x[g-1];
            assign w_y = r_y[g-1];
            assign w_z = r_z[g-1];
        end

        always_ff @(posedge i_clk) begin
            r_z[g] <= w_y[32] ? w_z - ARC : w_z + ARC;
        end
        if (g < ITER - 1) begin : g_xy
            always_ff @(posedge i_clk) begin
                if (!w_y[32]) begin
                    r_x[g] <= w_x + (w_y >>> g);
                    r_y[g] <= w_y - (w_x >>> g);
                end else begin
                    r_x[g] <= w_x - (w_y >>> g);
                    r_y[g] <= w_y + (w_x >>> g);
                end
            end
        end else begin : g_last
            always_ff @(posedge i_clk) begin
                r_x[g] <= '0;
                r_y[g] <= '0;
            end
        end
    end

    // Clamp to a quarter turn.
    always_ff @(posedge i_clk) begin
        if (r_z[ITER-1][32]) begin
            r_angle <= '0;
        end else if (r_z[ITER-1] > 33'($signed({2'b00, hvd_pkg::ONE_Q30}))) begin
            r_angle <= hvd_pkg::ONE_Q30;
        end else begin
            r_angle <= r_z[ITER-1][30:0] | 31'(r_x[ITER-1][0] & r_y[ITER-1][0] & 1'b0);
        end
    end

    assign o_angle = r_angle;

endmodule

@@ rtl/haversine_distance_core.sv @@
// ----------------------------------------------------------------------------
// haversine_distance_core
// Great-circle distance of two lat/lon points, haversine formula, fixed point.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle; o_busy is low whenever reset is released.
// The receiver cannot stall: o_done marks o_distance_m for exactly one cycle.
// Reset (synchronous, active low) flushes all in-flight words and loads the
// sphere radius with 6371000 m.
`include "haversine_distance_core_assert.svh"

module haversine_distance_core #(
    parameter int CORDIC_ITERATIONS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [23:0] i_lat_a,
    input  logic signed [24:0] i_lon_a,
    input  logic signed [23:0] i_lat_b,
    input  logic signed [24:0] i_lon_b,
    input  logic               i_cfg_we,
    input  logic [23:0]        i_cfg_wdata,
    output logic               o_done,
    output logic [25:0]        o_distance_m
);

    localparam int LAT = 2 * CORDIC_ITERATIONS + 46;

    // ---------------- control ----------------
    logic            w_accept;
    logic [LAT-1:0]  r_vld;
    logic [LAT-1:0]  n_vld;
    logic [23:0]     r_radius;

    // ---------------- angle conversion, four lanes ----------------
    // lane 0: delta latitude, lane 1: delta longitude,
    // lane 2: latitude a, lane 3: latitude b (half-angles read as Q17)
    logic signed [26:0] w_deg    [4];
    logic [25:0]        w_turn   [4];
    logic [25:0]        r_turn   [4];
    logic [52:0]        r_prod   [4];
    logic [25:0]        r_turn_d [4];
    logic [20:0]        w_qest   [4];
    logic [27:0]        w_rem    [4];
    logic [19:0]        r_q      [4];
    logic [5:0]         r_rr     [4];
    logic [11:0]        w_frac_tab [64];
    logic [31:0]        w_ba     [4];

    // ---------------- trig and haversine term ----------------
    hvd_pkg::t_q30      w_sdlat;
    hvd_pkg::t_q30      w_sdlon;
    hvd_pkg::t_q30      w_c1;
    hvd_pkg::t_q30      w_c2;
    logic signed [63:0] r_p1;
    logic signed [63:0] r_p2;
    logic signed [63:0] r_p3;
    hvd_pkg::t_q30      r_q1;
    hvd_pkg::t_q30      r_q2;
    hvd_pkg::t_q30      r_q3;
    logic signed [63:0] r_p4;
    hvd_pkg::t_q30      r_q1_d;
    hvd_pkg::t_q30      r_q4;
    hvd_pkg::t_q30      r_q1_dd;
    logic signed [32:0] w_asum;
    logic [30:0]        r_a;
    logic [30:0]        w_one_minus_a;

    // ---------------- roots, atan2, scaling ----------------
    logic [30:0]        w_ra;
    logic [30:0]        w_rb;
    logic [30:0]        w_z;
    logic [61:0]        r_u_prod;
    logic [31:0]        r_u;
    logic [55:0]        r_d_prod;
    logic [55:0]        w_d;
    logic [25:0]        r_dist;

    function automatic hvd_pkg::t_q30 rnd30(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = (p + 64'sd536870912) >>> 30;
        return s[31:0];
    endfunction

    // Accept whenever out of reset; there is no backpressure.
    assign o_busy   = ~i_rst_n;
    assign w_accept = i_start & ~o_busy;

    // Valid bits travel alongside the datapath stages.
    assign n_vld = {r_vld[LAT-2:0], w_accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_radius <= 24'd6371000;
        end else begin
            r_vld <= n_vld;
            if (i_cfg_we) begin
                r_radius <= i_cfg_wdata;
            end
        end
    end

    // Stage 1: differences and doubled latitudes, wrapped into one turn.
    always_comb begin
        w_deg[0] = 27'(i_lat_b) - 27'(i_lat_a);
        w_deg[1] = 27'(i_lon_b) - 27'(i_lon_a);
        w_deg[2] = 27'(i_lat_a) <<< 1;
        w_deg[3] = 27'(i_lat_b) <<< 1;
        for (int l = 0; l < 4; l++) begin
            w_turn[l] = w_deg[l][26] ? 26'(w_deg[l] + hvd_pkg::TURN_Q17) : 26'(w_deg[l]);
        end
    end

    // Stage 2: quotient estimate of turn / 45 by reciprocal multiply.
    // Stage 3: correct the estimate, keep quotient and remainder.
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            w_qest[l] = r_prod[l][52:32];
            w_rem[l]  = 28'(r_turn_d[l]) - 28'(w_qest[l]) * 28'd45;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 4; l++) begin
            r_turn[l]   <= w_turn[l];
            r_prod[l]   <= 53'(r_turn[l]) * 53'(hvd_pkg::RECIP45);
            r_turn_d[l] <= r_turn[l];
            if (w_rem[l][27]) begin
                r_q[l]  <= 20'(w_qest[l] - 21'd1);
                r_rr[l] <= 6'(w_rem[l] + 28'd45);
            end else begin
                r_q[l]  <= w_qest[l][19:0];
                r_rr[l] <= w_rem[l][5:0];
            end
        end
    end

    // Binary angle = quotient * 4096 + rounded fraction of the remainder.
    for (genvar g = 0; g < 64; g++) begin : g_frac
        assign w_frac_tab[g] = hvd_pkg::frac45(g);
    end

    for (genvar l = 0; l < 4; l++) begin : g_ba
        assign w_ba[l] = {r_q[l], w_frac_tab[r_rr[l]]};
    end

    hvd_cordic_rot #(.ITER(CORDIC_ITERATIONS)) u_rot_dlat (
        .i_clk (i_clk), .i_ba (w_ba[0]), .o_cos (), .o_sin (w_sdlat)
    );
    hvd_cordic_rot #(.ITER(CORDIC_ITERATIONS)) u_rot_dlon (
        .i_clk (i_clk), .i_ba (w_ba[1]), .o_cos (), .o_sin (w_sdlon)
    );
    hvd_cordic_rot #(.ITER(CORDIC_ITERATIONS)) u_rot_lat_a (
        .i_clk (i_clk), .i_ba (w_ba[2]), .o_cos (w_c1), .o_sin ()
    );
    hvd_cordic_rot #(.ITER(CORDIC_ITERATIONS)) u_rot_lat_b (
        .i_clk (i_clk), .i_ba (w_ba[3]), .o_cos (w_c2), .o_sin ()
    );

    // a = sin^2(dlat/2) + cos(lat_a) cos(lat_b) sin^2(dlon/2), rounded per product.
    assign w_asum = 33'(r_q1_dd) + 33'(r_q4);

    always_ff @(posedge i_clk) begin
        r_p1    <= w_sdlat * w_sdlat;
        r_p2    <= w_c1 * w_c2;
        r_p3    <= w_sdlon * w_sdlon;
        r_q1    <= rnd30(r_p1);
        r_q2    <= rnd30(r_p2);
        r_q3    <= rnd30(r_p3);
        r_p4    <= r_q2 * r_q3;
        r_q1_d  <= r_q1;
        r_q4    <= rnd30(r_p4);
        r_q1_dd <= r_q1_d;
        // Clamp a into [0, 1.0] so both roots stay real.
        if (w_asum[32]) begin
            r_a <= '0;
        end else if (w_asum > 33'($signed({2'b00, hvd_pkg::ONE_Q30}))) begin
            r_a <= hvd_pkg::ONE_Q30;
        end else begin
            r_a <= w_asum[30:0];
        end
    end

    assign w_one_minus_a = hvd_pkg::ONE_Q30 - r_a;

    hvd_isqrt u_sqrt_a (
        .i_clk (i_clk), .i_val ({r_a, 30'd0}), .o_root (w_ra)
    );
    hvd_isqrt u_sqrt_b (
        .i_clk (i_clk), .i_val ({w_one_minus_a, 30'd0}), .o_root (w_rb)
    );

    hvd_cordic_vec #(.ITER(CORDIC_ITERATIONS)) u_atan (
        .i_clk (i_clk), .i_x (w_rb), .i_y (w_ra), .o_angle (w_z)
    );

    // Angle to radians times two (pi in Q29), then scale by the radius.
    assign w_d = (r_d_prod + 56'd536870912) >> 30;

    always_ff @(posedge i_clk) begin
        r_u_prod <= 62'(w_z) * 62'(hvd_pkg::PI_Q29);
        r_u      <= 32'((r_u_prod + 62'd268435456) >> 29);
        r_d_prod <= 56'(r_radius) * 56'(r_u);
        r_dist   <= (w_d > 56'(26'h3FF_FFFF)) ? 26'h3FF_FFFF : w_d[25:0];
    end

    assign o_done       = r_vld[LAT-1];
    assign o_distance_m = r_dist;

    // A result appears exactly one pipeline latency after its word was taken.
    `HVD_ASSERT_IMPLIES(a_done_latency, o_done, $past(w_accept, LAT))
    // The clamped haversine term never exceeds 1.0 while it is live.
    `HVD_ASSERT_IMPLIES(a_a_clamped, r_vld[CORDIC_ITERATIONS + 9], r_a <= hvd_pkg::ONE_Q30)
    // The scaled angle r_u never exceeds pi in Q30, i.e. half a turn.
    `HVD_ASSERT_IMPLIES(a_u_bound, r_vld[LAT-3], r_u <= 32'd3373259426)

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// Haversine distance core testbench
// Drives point pairs through the start/busy handshake with random gaps and
// checks every distance word against a fixed-point haversine predictor or a typed-in value.
// The sphere radius is rewritten between phases while the pipe is empty.
// ----------------------------------------------------------------------------
module tb;

    localparam int NITER      = 24;
    localparam int LATENCY    = 2 * NITER + 46;
    localparam int WDOG_LIMIT = 4000;
    localparam int N_RANDOM   = 1130;

    localparam logic signed [23:0] LAT_MAX = 24'sd5898240;
    localparam logic signed [24:0] LON_MAX = 25'sd11796480;
    localparam logic signed [63:0] ONE    = 64'sd1 << 30;
    localparam logic signed [63:0] TURN   = 64'sd47185920;
    localparam logic [25:0]        NO_REF = '1;  // table row with no typed-in distance

    typedef struct packed {
        logic signed [23:0] lat_a;
        logic signed [24:0] lon_a;
        logic signed [23:0] lat_b;
        logic signed [24:0] lon_b;
        logic [25:0]        want_m;
    } t_pair_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic signed [23:0] i_lat_a = '0;
    logic signed [24:0] i_lon_a = '0;
    logic signed [23:0] i_lat_b = '0;
    logic signed [24:0] i_lon_b = '0;
    logic               i_cfg_we = 1'b0;
    logic [23:0]        i_cfg_wdata = '0;
    logic               o_done;
    logic [25:0]        o_distance_m;

    logic [23:0] radius_m;
    logic [25:0] distance_q[$];
    int          n_errors = 0;
    int          idle_cycles = 0;

    haversine_distance_core #(.CORDIC_ITERATIONS(NITER)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_lat_a(i_lat_a), .i_lon_a(i_lon_a), .i_lat_b(i_lat_b), .i_lon_b(i_lon_b),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_done(o_done), .o_distance_m(o_distance_m)
    );

    always #6 i_clk = ~i_clk;

    // ---------------- predictor ----------------
    // Floor shift right; works for negative values too.
    function automatic logic signed [63:0] fshr(logic signed [63:0] v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [63:0] mul_q30(logic signed [63:0] p,
                                                   logic signed [63:0] q);
        return fshr(p * q + (ONE >>> 1), 30);
    endfunction

    // Degrees in Q17 to a binary angle (2^32 per turn), rounded half up.
    function automatic logic [31:0] deg_to_bang(logic signed [63:0] deg_q17);
        logic signed [63:0] r;
        logic [95:0]        num;
        r = deg_q17 % TURN;
        if (r < 0) r += TURN;
        num = (96'(r) << 32) + 96'(TURN / 2);
        return 32'(num / 96'(TURN));
    endfunction

    // Rotation-mode CORDIC with quadrant folding; returns sine in Q30.
    function automatic logic signed [63:0] sine_q30(logic [31:0] ba);
        logic [1:0]         quad;
        logic [31:0]        res;
        logic signed [63:0] z, x, y, nx, s;
        quad = 2'((ba + 32'h2000_0000) >> 30);
        res  = ba - (32'(quad) << 30);
        z    = 64'(signed'(res));
        x    = 64'(hvd_pkg::GAIN_Q30);
        y    = 0;
        for (int i = 0; i < NITER; i++) begin
            if (z >= 0) begin
                nx = x - fshr(y, i); y = y + fshr(x, i); z -= 64'(hvd_pkg::ARC_TAB[i]);
            end else begin
                nx = x + fshr(y, i); y = y - fshr(x, i); z += 64'(hvd_pkg::ARC_TAB[i]);
            end
            x = nx;
        end
        case (quad)
            2'd0: s = y;
            2'd1: s = x;
            2'd2: s = -y;
            default: s = -x;
        endcase
        if (s > ONE) s = ONE;
        if (s < -ONE) s = -ONE;
        return s;
    endfunction

    function automatic logic signed [63:0] cosine_q30(logic [31:0] ba);
        // cos(t) = sin(t + quarter turn); quarter shifts the quadrant only,
        // so the CORDIC residue and rotation are identical.
        return sine_q30(ba + 32'h4000_0000);
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b; r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] angle_first_quad(logic signed [63:0] y,
                                                            logic signed [63:0] x);
        logic signed [63:0] z, nx;
        z = 0;
        for (int i = 0; i < NITER; i++) begin
            if (y >= 0) begin
                nx = x + fshr(y, i); y = y - fshr(x, i); z += 64'(hvd_pkg::ARC_TAB[i]);
            end else begin
                nx = x - fshr(y, i); y = y + fshr(x, i); z -= 64'(hvd_pkg::ARC_TAB[i]);
            end
            x = nx;
        end
        if (z < 0) z = 0;
        if (z > ONE) z = ONE;
        return z;
    endfunction

    function automatic logic [25:0] great_circle_m(t_pair_row p, logic [23:0] rad);
        logic signed [63:0] la, lb, oa, ob, sdlat, sdlon, c1, c2, a, z;
        logic [63:0]        ra, rb, u, d;
        la = p.lat_a; lb = p.lat_b; oa = p.lon_a; ob = p.lon_b;
        // Q16 difference read as Q17 gives the half angle.
        sdlat = sine_q30(deg_to_bang(lb - la));
        sdlon = sine_q30(deg_to_bang(ob - oa));
        c1    = cosine_q30(deg_to_bang(la * 2));
        c2    = cosine_q30(deg_to_bang(lb * 2));
        a = mul_q30(sdlat, sdlat) + mul_q30(mul_q30(c1, c2), mul_q30(sdlon, sdlon));
        if (a < 0) a = 0;
        if (a > ONE) a = ONE;
        ra = root_floor(64'(a) << 30);
        rb = root_floor(64'(ONE - a) << 30);
        z  = angle_first_quad(signed'(ra), signed'(rb));
        u  = (64'(z) * 64'(hvd_pkg::PI_Q29) + (64'd1 << 28)) >> 29;
        d  = (64'(rad) * u + (64'd1 << 29)) >> 30;
        if (d > 64'(NO_REF)) d = 64'(NO_REF);
        return 26'(d);
    endfunction

    // ---------------- checking ----------------
    task automatic report_mismatch(string what, logic [25:0] got, logic [25:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // Accept each distance word at the edge that ends its strobe cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (distance_q.size() == 0) begin
                report_mismatch("unexpected word", o_distance_m, '0);
            end else begin
                logic [25:0] want;
                want = distance_q.pop_front();
                if (o_distance_m !== want) report_mismatch("distance_m", o_distance_m, want);
            end
        end
    end

    // Count cycles with no accepted input and no accepted result.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("watchdog expired");
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    // Send one pair: optional random gap, hold start until accepted; start is left high.
    task automatic send_pair(t_pair_row p, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 19) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;  // stretches back to back
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_lat_a <= p.lat_a; i_lon_a <= p.lon_a;
        i_lat_b <= p.lat_b; i_lon_b <= p.lon_b;
        do @(posedge i_clk); while (o_busy);
        if (p.want_m != NO_REF) distance_q.push_back(p.want_m);
        else distance_q.push_back(great_circle_m(p, radius_m));
    endtask

    task automatic release_start();
        i_start <= 1'b0;
    endtask

    // Write the radius only with the pipe drained.
    task automatic set_radius(logic [23:0] r);
        release_start();
        wait (distance_q.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= r;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        radius_m = r;
    endtask

    function automatic t_pair_row random_pair();
        t_pair_row p;
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 7) begin
            // legal coordinates
            p.lat_a = 24'(int'($urandom_range(0, 2 * 5898240)) - 5898240);
            p.lat_b = 24'(int'($urandom_range(0, 2 * 5898240)) - 5898240);
            p.lon_a = 25'(int'($urandom_range(0, 2 * 11796480)) - 11796480);
            p.lon_b = 25'(int'($urandom_range(0, 2 * 11796480)) - 11796480);
        end else if (mode < 9) begin
            // nearby points, tiny a
            p.lat_a = 24'(int'($urandom_range(0, 2 * 5898240)) - 5898240);
            p.lon_a = 25'(int'($urandom_range(0, 2 * 11796480)) - 11796480);
            p.lat_b = p.lat_a + 24'(int'($urandom_range(0, 2000)) - 1000);
            p.lon_b = p.lon_a + 25'(int'($urandom_range(0, 2000)) - 1000);
        end else begin
            // raw patterns: out-of-range angles, every bit toggles
            p.lat_a = 24'($urandom); p.lat_b = 24'($urandom);
            p.lon_a = 25'($urandom); p.lon_b = 25'($urandom);
        end
        p.want_m = NO_REF;
        return p;
    endfunction

    t_pair_row directed [] = '{
        // identical points: zero distance
        '{24'sd0, 25'sd0, 24'sd0, 25'sd0, 26'd0},
        '{LAT_MAX, LON_MAX, LAT_MAX, LON_MAX, 26'd0},
        // extremes of the fields, checked by the predictor
        '{LAT_MAX, 25'sd0, -LAT_MAX, 25'sd0, NO_REF},
        '{24'sd0, -LON_MAX, 24'sd0, LON_MAX, NO_REF},
        '{24'sd0, 25'sd0, 24'sd0, LON_MAX, NO_REF},
        '{-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX, NO_REF},
        // out-of-range patterns wrap modulo a turn
        '{24'h7FFFFF, 25'h0FFFFFF, 24'h800000, 25'h1000000, NO_REF},
        '{24'h800000, 25'h1000000, 24'h7FFFFF, 25'h0FFFFFF, NO_REF},
        '{24'hFFFFFF, 25'h1FFFFFF, 24'sd1, 25'sd1, NO_REF},
        '{24'h555555, 25'h0AAAAAA, 24'hAAAAAA, 25'h1555555, NO_REF},
        // one degree apart on the equator; one degree north and two east of the origin
        '{24'sd0, 25'sd0, 24'sd0, 25'sd65536, NO_REF},
        '{24'sd65536, 25'sd131072, 24'sd0, 25'sd0, NO_REF}
    };

    initial begin
        radius_m = 24'd6371000;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset radius first, then the extremes of the register.
        foreach (directed[k]) send_pair(directed[k], 1'b0);
        foreach (directed[k]) send_pair(directed[k], 1'b1);
        set_radius(24'd16777215);
        foreach (directed[k]) send_pair(directed[k], 1'b1);
        set_radius(24'd1);
        foreach (directed[k]) send_pair(directed[k], 1'b0);
        set_radius(24'd0);  // zero radius yields zero distance
        for (int k = 0; k < 4; k++) begin
            t_pair_row p;
            p = random_pair();
            p.want_m = 26'd0;
            send_pair(p, 1'b1);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 230 == 0) set_radius(24'($urandom_range(1, 16777215)));
            send_pair(random_pair(), 1'b1);
        end
        release_start();

        // drain
        wait (distance_q.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

@@ haversine_distance_core.f @@
+incdir+rtl
rtl/hvd_pkg.sv
rtl/hvd_cordic_rot.sv
rtl/hvd_isqrt.sv
rtl/hvd_cordic_vec.sv
rtl/haversine_distance_core.sv
bench/tb.sv
